// ===== rtl/frt_pkg.sv =====
// shared constants, result codes and control types of the fragment reassembly tracker
`default_nettype none
package frt_pkg;

   localparam int MAX_SOURCES_DEF      = 8;
   localparam int FRAGMENT_PAYLOAD_DEF = 246;
   localparam int NUM_PKT_TYPES_DEF    = 16;

   localparam logic [7:0] HDR_BYTES = 8'd4;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_W      = 16;

   // result status codes
   localparam logic [3:0] ST_SHORT      = 4'd0;
   localparam logic [3:0] ST_BAD_LEN    = 4'd1;
   localparam logic [3:0] ST_BAD_TYPE   = 4'd2;
   localparam logic [3:0] ST_SINGLE_OK  = 4'd3;
   localparam logic [3:0] ST_SINGLE_UNH = 4'd4;
   localparam logic [3:0] ST_STORED     = 4'd5;
   localparam logic [3:0] ST_CLUSTER_OK = 4'd6;
   localparam logic [3:0] ST_CLUSTER_UNH = 4'd7;
   localparam logic [3:0] ST_ORDER_DROP = 4'd8;
   localparam logic [3:0] ST_NO_START   = 4'd9;
   localparam logic [3:0] ST_NO_SLOT    = 4'd10;

   typedef struct packed {
      logic load;    // capture request fields
      logic calc;    // register offset products
      logic rd;      // read table entry at scan address
      logic chk;     // compare entry read in the previous cycle
      logic finish;  // apply table update and load result
   } frt_cmd_type;

   typedef struct packed {
      logic multi;   // request belongs to a multi-fragment cluster
   } frt_sts_type;

endpackage
`default_nettype wire

// ===== rtl/frt_datapath.sv =====
// request registers, source table memories, lookup tracking and decision logic
`default_nettype none
module frt_datapath
   import frt_pkg::*;
#(
   parameter int MAX_SOURCES      = MAX_SOURCES_DEF,
   parameter int FRAGMENT_PAYLOAD = FRAGMENT_PAYLOAD_DEF,
   parameter int NUM_PKT_TYPES    = NUM_PKT_TYPES_DEF,
   localparam int SLOT_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire frt_cmd_type           cmd,
   input  wire logic [SLOT_W-1:0]     scan_addr,
   output frt_sts_type                sts,
   input  wire logic [REQ_DATA_W-1:0] req_data,
   input  wire logic [7:0]            req_type,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_W-1:0]      csr_wr_data,
   output logic [RSP_DATA_W-1:0]      rsp_data,
   output logic [7:0]                 rsp_type
);

   localparam logic [15:0] FP16 = 16'(FRAGMENT_PAYLOAD);
   localparam logic [7:0]  NT8  = 8'(NUM_PKT_TYPES);

   logic [CSR_W-1:0] handler_enable_ff;

   logic [47:0] mac_ff;
   logic [7:0]  flen_ff, plen_ff, type_ff, count_ff, idx_ff;
   logic [15:0] woff_prod_ff, tot_prod_ff;

   logic [MAX_SOURCES-1:0] valid_ff, valid_in;
   logic [47:0] src_mem [MAX_SOURCES];
   logic [7:0]  exp_mem [MAX_SOURCES];
   logic [47:0] src_rd_ff;
   logic [7:0]  exp_rd_ff;
   logic [SLOT_W-1:0] chk_idx_ff;

   logic              hit_ff, avail_ff;
   logic [SLOT_W-1:0] hit_idx_ff, avail_idx_ff;
   logic [7:0]        hit_exp_ff;

   logic [3:0]  res_status_ff;
   logic [2:0]  res_slot_ff;
   logic [15:0] res_woff_ff, res_total_ff;
   logic [7:0]  res_clen_ff, res_type_ff;

   // decision
   logic [3:0]  st;
   logic [SLOT_W-1:0] sl;
   logic [15:0] woff, tot;
   logic [7:0]  clen, clen_o, ot, next_exp, exp_wd;
   logic        bad_type, handled;
   logic        clr_en, set_en, src_we, exp_we;
   logic [SLOT_W-1:0] clr_idx, wr_idx;
   logic        entry_match;

   assign sts.multi = (flen_ff >= HDR_BYTES) && (plen_ff >= HDR_BYTES) && (count_ff > 8'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         handler_enable_ff <= '0;
      end else if (csr_wr_en) begin
         handler_enable_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mac_ff   <= req_data[47:0];
         flen_ff  <= req_data[55:48];
         plen_ff  <= req_data[63:56];
         count_ff <= req_data[71:64];
         idx_ff   <= req_data[79:72];
         type_ff  <= req_type;
      end
      if (cmd.calc) begin
         woff_prod_ff <= 16'(idx_ff) * FP16;
         tot_prod_ff  <= 16'(count_ff - 8'd1) * FP16;
      end
   end

   // table memories
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         src_rd_ff  <= src_mem[scan_addr];
         exp_rd_ff  <= exp_mem[scan_addr];
         chk_idx_ff <= scan_addr;
      end
      if (cmd.finish && src_we) begin
         src_mem[wr_idx] <= mac_ff;
      end
      if (cmd.finish && exp_we) begin
         exp_mem[wr_idx] <= exp_wd;
      end
   end

   assign entry_match = valid_ff[chk_idx_ff] && (src_rd_ff == mac_ff);

   // first matching entry, and first entry usable by a start fragment
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff   <= 1'b0;
         avail_ff <= 1'b0;
      end else if (cmd.chk) begin
         if (entry_match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= chk_idx_ff;
            hit_exp_ff <= exp_rd_ff;
         end
         if ((!valid_ff[chk_idx_ff] || entry_match) && !avail_ff) begin
            avail_ff     <= 1'b1;
            avail_idx_ff <= chk_idx_ff;
         end
      end
   end

   // a start may free the sender's old slot and take a new one in the same cycle
   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish) begin
         if (clr_en) begin
            valid_in[clr_idx] = 1'b0;
         end
         if (set_en) begin
            valid_in[wr_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      clen     = plen_ff - HDR_BYTES;
      bad_type = type_ff >= NT8;
      handled  = handler_enable_ff[type_ff[3:0]];
      next_exp = hit_exp_ff + 8'd1;
      st       = ST_SHORT;
      sl       = '0;
      woff     = '0;
      tot      = '0;
      clen_o   = '0;
      ot       = '0;
      clr_en   = 1'b0;
      set_en   = 1'b0;
      src_we   = 1'b0;
      exp_we   = 1'b0;
      clr_idx  = hit_idx_ff;
      wr_idx   = hit_idx_ff;
      exp_wd   = next_exp;
      if (flen_ff < HDR_BYTES) begin
         st = ST_SHORT;
      end else if (plen_ff < HDR_BYTES) begin
         st = ST_BAD_LEN;
      end else if (count_ff <= 8'd1) begin
         clen_o = clen;
         if (bad_type) begin
            st = ST_BAD_TYPE;
         end else begin
            st  = handled ? ST_SINGLE_OK : ST_SINGLE_UNH;
            tot = 16'(clen);
            ot  = type_ff;
         end
      end else if (idx_ff == 8'd0) begin
         // start drops an open entry of the sender, then takes the lowest free slot
         clr_en = hit_ff;
         if (!avail_ff) begin
            st = ST_NO_SLOT;
         end else begin
            set_en = 1'b1;
            src_we = 1'b1;
            exp_we = 1'b1;
            wr_idx = avail_idx_ff;
            exp_wd = 8'd1;
            st     = ST_STORED;
            sl     = avail_idx_ff;
            clen_o = clen;
            woff   = woff_prod_ff;
         end
      end else if (!hit_ff) begin
         st = ST_NO_START;
      end else begin
         sl = hit_idx_ff;
         if (idx_ff != hit_exp_ff) begin
            clr_en = 1'b1;
            st     = ST_ORDER_DROP;
         end else begin
            clen_o = clen;
            woff   = woff_prod_ff;
            exp_we = 1'b1;
            if (next_exp == count_ff) begin
               clr_en = 1'b1;
               if (bad_type) begin
                  st = ST_BAD_TYPE;
               end else begin
                  st  = handled ? ST_CLUSTER_OK : ST_CLUSTER_UNH;
                  tot = tot_prod_ff + 16'(clen);
                  ot  = type_ff;
               end
            end else begin
               st = ST_STORED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_status_ff <= st;
         res_slot_ff   <= 3'(sl);
         res_woff_ff   <= woff;
         res_clen_ff   <= clen_o;
         res_total_ff  <= tot;
         res_type_ff   <= ot;
      end
   end

   assign rsp_data = {1'b0, res_total_ff, res_clen_ff, res_woff_ff, res_slot_ff, res_status_ff};
   assign rsp_type = res_type_ff;

endmodule
`default_nettype wire

// ===== rtl/frt_controller.sv =====
// sequencer: request intake, table scan, decision and result handshake
`default_nettype none
module frt_controller
   import frt_pkg::*;
#(
   parameter int MAX_SOURCES = MAX_SOURCES_DEF,
   localparam int SLOT_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output frt_cmd_type            cmd,
   output logic [SLOT_W-1:0]      scan_addr,
   input  wire frt_sts_type       sts
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CALC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_FINAL = 3'd4;

   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_SOURCES - 1);

   logic [2:0]        state_ff, state_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign scan_addr = cnt_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            cnt_in   = '0;
            state_in = sts.multi ? S_SCAN : S_FINAL;
         end
         S_SCAN: begin
            // read entry cnt while checking the one read before
            cmd.rd  = 1'b1;
            cmd.chk = (cnt_ff != '0);
            if (cnt_ff == LAST_IDX) begin
               state_in = S_LAST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_LAST: begin
            cmd.chk  = 1'b1;
            state_in = S_FINAL;
         end
         S_FINAL: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/fragment_reassembly_tracker.sv =====
// top level of the fragment reassembly tracker
//
//   port group | dir | contents
//   req_*      | in  | one frame header per request
//   rsp_*      | out | one decision per request
//   csr_*      | in  | handler_enable register write
//
// a single-packet or rejected frame goes from the idle state through the calc state
// to the final state; a cluster fragment first passes the scan of the source table,
// one entry per cycle through its read port.
// reset clears the table valid bits, handler_enable and any pending result.
// the next request is taken while a finished result waits on rsp_tready.
`default_nettype none
module fragment_reassembly_tracker
   import frt_pkg::*;
#(
   parameter int MAX_SOURCES      = MAX_SOURCES_DEF,
   parameter int FRAGMENT_PAYLOAD = FRAGMENT_PAYLOAD_DEF,
   parameter int NUM_PKT_TYPES    = NUM_PKT_TYPES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // src_mac[47:0], frame_len[55:48], hdr_pkt_len[63:56],
   // cluster_count[71:64], cluster_index[79:72]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // pkt_type[7:0]
   input  wire logic [7:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status[3:0], slot[6:4], write_offset[22:7], copy_len[30:23],
   // total_len[46:31], zero[47]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // out_type[7:0]
   output logic [7:0]                 rsp_tuser,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_W-1:0]      csr_wr_data
);

   localparam int SLOT_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

   frt_cmd_type       cmd;
   frt_sts_type       sts;
   logic [SLOT_W-1:0] scan_addr;

   frt_controller #(
      .MAX_SOURCES (MAX_SOURCES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .scan_addr (scan_addr),
      .sts       (sts)
   );

   frt_datapath #(
      .MAX_SOURCES      (MAX_SOURCES),
      .FRAGMENT_PAYLOAD (FRAGMENT_PAYLOAD),
      .NUM_PKT_TYPES    (NUM_PKT_TYPES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .scan_addr   (scan_addr),
      .sts         (sts),
      .req_data    (req_tdata),
      .req_type    (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_data    (rsp_tdata),
      .rsp_type    (rsp_tuser)
   );

endmodule
`default_nettype wire

// ===== tb/sv/frt_decision_checker.sv =====
// checker: predicts each frame decision of the fragment reassembly tracker and compares it
`timescale 1ns / 1ps
module frt_decision_checker
   import frt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // src_mac[47:0], frame_len[55:48], hdr_pkt_len[63:56],
   // cluster_count[71:64], cluster_index[79:72]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // pkt_type[7:0]
   input  wire logic [7:0]            req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status[3:0], slot[6:4], write_offset[22:7], copy_len[30:23],
   // total_len[46:31], zero[47]
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   // out_type[7:0]
   input  wire logic [7:0]            rsp_tuser,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_W-1:0]      csr_wr_data,
   output int                         mismatch_count,
   output int                         decisions_due
);

   typedef struct packed {
      logic [47:0] mac;
      logic [7:0]  frame_len;
      logic [7:0]  pkt_len;
      logic [7:0]  pkt_type;
      logic [7:0]  frag_count;
      logic [7:0]  frag_index;
   } frame_hdr_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [2:0]  slot;
      logic [15:0] write_offset;
      logic [7:0]  copy_len;
      logic [15:0] total_len;
      logic [7:0]  out_type;
   } frame_decision_type;

   logic [CSR_W-1:0] enable_mask;
   bit               slot_open [MAX_SOURCES_DEF];
   logic [47:0]      slot_mac  [MAX_SOURCES_DEF];
   logic [7:0]       slot_next [MAX_SOURCES_DEF];

   frame_decision_type pending_decisions [$];

   // updates the source table and works out the decision for one frame header
   task automatic track_frame(input frame_hdr_type h, output frame_decision_type d);
      int s;
      d = '0;
      s = -1;
      if (h.frame_len < HDR_BYTES) begin
         d.status = ST_SHORT;
      end else if (h.pkt_len < HDR_BYTES) begin
         d.status = ST_BAD_LEN;
      end else if (h.frag_count <= 8'd1) begin
         d.copy_len = h.pkt_len - HDR_BYTES;
         if (h.pkt_type >= NUM_PKT_TYPES_DEF) begin
            d.status = ST_BAD_TYPE;
         end else begin
            d.status    = enable_mask[h.pkt_type[3:0]] ? ST_SINGLE_OK : ST_SINGLE_UNH;
            d.total_len = 16'(d.copy_len);
            d.out_type  = h.pkt_type;
         end
      end else begin
         for (int i = MAX_SOURCES_DEF - 1; i >= 0; i--)
            if (slot_open[i] && slot_mac[i] == h.mac) s = i;
         if (h.frag_index == 8'd0) begin
            // a start drops any open entry of its sender, then takes the lowest free slot
            if (s >= 0) slot_open[s] = 1'b0;
            s = -1;
            for (int i = MAX_SOURCES_DEF - 1; i >= 0; i--)
               if (!slot_open[i]) s = i;
            if (s >= 0) begin
               slot_open[s] = 1'b1;
               slot_mac[s]  = h.mac;
               slot_next[s] = 8'd0;
            end
         end
         if (s < 0) begin
            d.status = (h.frag_index == 8'd0) ? ST_NO_SLOT : ST_NO_START;
         end else begin
            d.slot = 3'(s);
            if (h.frag_index != slot_next[s]) begin
               slot_open[s] = 1'b0;
               d.status     = ST_ORDER_DROP;
            end else begin
               d.copy_len     = h.pkt_len - HDR_BYTES;
               d.write_offset = 16'(int'(h.frag_index) * FRAGMENT_PAYLOAD_DEF);
               slot_next[s]   = slot_next[s] + 8'd1;
               if (slot_next[s] == h.frag_count) begin
                  // last fragment: slot is freed even when the type is bad
                  slot_open[s] = 1'b0;
                  if (h.pkt_type >= NUM_PKT_TYPES_DEF) begin
                     d.status = ST_BAD_TYPE;
                  end else begin
                     d.status    = enable_mask[h.pkt_type[3:0]] ? ST_CLUSTER_OK
                                                                : ST_CLUSTER_UNH;
                     d.total_len = 16'((int'(h.frag_count) - 1) * FRAGMENT_PAYLOAD_DEF
                                       + int'(d.copy_len));
                     d.out_type  = h.pkt_type;
                  end
               end else begin
                  d.status = ST_STORED;
               end
            end
         end
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : watch_channels
      frame_hdr_type      hdr;
      frame_decision_type want;
      frame_decision_type got;
      if (reset) begin
         enable_mask    = '0;
         mismatch_count = 0;
         pending_decisions.delete();
         for (int i = 0; i < MAX_SOURCES_DEF; i++) slot_open[i] = 1'b0;
      end else begin
         if (csr_wr_en) enable_mask = csr_wr_data;
         if (req_tvalid && req_tready) begin
            hdr.mac        = req_tdata[47:0];
            hdr.frame_len  = req_tdata[55:48];
            hdr.pkt_len    = req_tdata[63:56];
            hdr.frag_count = req_tdata[71:64];
            hdr.frag_index = req_tdata[79:72];
            hdr.pkt_type   = req_tuser;
            track_frame(hdr, want);
            pending_decisions.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status       = rsp_tdata[3:0];
            got.slot         = rsp_tdata[6:4];
            got.write_offset = rsp_tdata[22:7];
            got.copy_len     = rsp_tdata[30:23];
            got.total_len    = rsp_tdata[46:31];
            got.out_type     = rsp_tuser;
            if (pending_decisions.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no request waiting, expected none, got status %0d",
                        $time, got.status);
            end else begin
               want = pending_decisions.pop_front();
               check_field("status", want.status, got.status);
               check_field("slot", want.slot, got.slot);
               check_field("write_offset", want.write_offset, got.write_offset);
               check_field("copy_len", want.copy_len, got.copy_len);
               check_field("total_len", want.total_len, got.total_len);
               check_field("out_type", want.out_type, got.out_type);
            end
         end
      end
      decisions_due = pending_decisions.size();
   end

endmodule

// ===== tb/sv/fragment_reassembly_tracker_tb.sv =====
// testbench top: frame header stimulus, handler_enable writes and verdict for the tracker
`timescale 1ns / 1ps
module fragment_reassembly_tracker_tb;
   import frt_pkg::*;

   localparam int NUM_SENDERS     = 10;
   localparam int LONG_SENDER     = 2;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_pattern_type;

   typedef struct packed {
      logic [47:0] mac;
      logic [7:0]  frame_len;
      logic [7:0]  pkt_len;
      logic [7:0]  pkt_type;
      logic [7:0]  frag_count;
      logic [7:0]  frag_index;
   } frame_hdr_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [7:0]            req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [7:0]            rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_W-1:0]      csr_wr_data = '0;
   int                    mismatch_count;
   int                    decisions_due;
   bit                    hold_off_go = 1'b0;

   // sender pool and the cluster each one is walking through
   logic [47:0] sender_mac   [NUM_SENDERS];
   bit          sender_open  [NUM_SENDERS];
   int          sender_next  [NUM_SENDERS];
   int          sender_count [NUM_SENDERS];
   bit          long_done = 1'b0;

   always #5 clock = ~clock;

   fragment_reassembly_tracker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   frt_decision_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .decisions_due  (decisions_due)
   );

   function automatic frame_hdr_type frame_of(input logic [47:0] mac, input int flen,
                                              input int plen, input int ptype,
                                              input int count, input int idx);
      frame_hdr_type f;
      f.mac        = mac;
      f.frame_len  = 8'(flen);
      f.pkt_len    = 8'(plen);
      f.pkt_type   = 8'(ptype);
      f.frag_count = 8'(count);
      f.frag_index = 8'(idx);
      return f;
   endfunction

   // called at a falling edge, returns at the falling edge after the request is taken
   task automatic send_frame(input frame_hdr_type f);
      req_tvalid <= 1'b1;
      req_tdata  <= {f.frag_index, f.frag_count, f.pkt_len, f.frame_len, f.mac};
      req_tuser  <= f.pkt_type;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pause(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic write_enable_mask(input logic [CSR_W-1:0] mask);
      req_tvalid <= 1'b0;
      while (decisions_due != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mask;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic next_random_frame(output frame_hdr_type f);
      int roll;
      int s;
      roll         = $urandom_range(0, 99);
      f.mac        = sender_mac[$urandom_range(0, NUM_SENDERS - 1)];
      f.frame_len  = 8'($urandom_range(4, 250));
      f.pkt_len    = 8'($urandom_range(4, 255));
      f.pkt_type   = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                                  : 8'($urandom_range(16, 255));
      f.frag_count = 8'($urandom_range(0, 1));
      f.frag_index = 8'($urandom);
      if (roll < 6) begin
         // noise, kept away from the long cluster
         if ($urandom_range(0, 1) || f.mac == sender_mac[LONG_SENDER])
            f.mac = {16'($urandom), 32'($urandom)};
         f.frame_len  = 8'($urandom_range(0, 250));
         f.pkt_len    = 8'($urandom);
         f.pkt_type   = 8'($urandom);
         f.frag_count = 8'($urandom);
      end else if (roll < 10) begin
         if ($urandom_range(0, 1)) f.frame_len = 8'($urandom_range(0, 3));
         else f.pkt_len = 8'($urandom_range(0, 3));
         f.frag_count = 8'($urandom);
      end else if (roll >= 18) begin
         if (!long_done && $urandom_range(0, 99) < 60) s = LONG_SENDER;
         else s = $urandom_range(0, NUM_SENDERS - 1);
         f.mac = sender_mac[s];
         if (!sender_open[s]) begin
            if (s == LONG_SENDER && !long_done)
               sender_count[s] = $urandom_range(0, 1) ? 255 : $urandom_range(160, 254);
            else if ($urandom_range(0, 19) == 0)
               sender_count[s] = $urandom_range(7, 40);
            else
               sender_count[s] = $urandom_range(2, 6);
            sender_open[s] = 1'b1;
            sender_next[s] = 0;
         end
         f.frag_count = 8'(sender_count[s]);
         if (s != LONG_SENDER && sender_next[s] > 0 && $urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 2))
               0: begin
                  f.frag_index   = 8'(sender_next[s] + $urandom_range(1, 3));
                  sender_open[s] = 1'b0;
               end
               1: begin
                  f.frag_index   = 8'(sender_next[s] - 1);
                  sender_open[s] = 1'b0;
               end
               default: begin
                  // restart while the cluster is still open
                  sender_count[s] = $urandom_range(2, 6);
                  f.frag_count    = 8'(sender_count[s]);
                  f.frag_index    = 8'd0;
                  sender_next[s]  = 1;
               end
            endcase
         end else begin
            f.frag_index = 8'(sender_next[s]);
            sender_next[s]++;
            if (sender_next[s] == sender_count[s]) begin
               sender_open[s] = 1'b0;
               if (s == LONG_SENDER) long_done = 1'b1;
            end
         end
      end
   endtask

   initial begin : stimulus
      frame_hdr_type    f;
      int               sent;
      int               burst;
      logic [CSR_W-1:0] mask;
      sender_mac[0] = '0;
      sender_mac[1] = '1;
      for (int i = 2; i < NUM_SENDERS; i++) sender_mac[i] = {16'($urandom), 32'($urandom)};
      for (int i = 0; i < NUM_SENDERS; i++) sender_open[i] = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // types 0,1,6,7,8,10,13,15 handled, type 2 not
      write_enable_mask(16'hA5C3);
      send_frame(frame_of(sender_mac[3], 0, 8, 0, 0, 0));
      send_frame(frame_of(sender_mac[3], 3, 255, 0, 3, 1));
      send_frame(frame_of(sender_mac[3], 250, 3, 0, 0, 0));
      send_frame(frame_of(sender_mac[3], 4, 255, 0, 0, 0));
      send_frame(frame_of(sender_mac[1], 250, 4, 15, 1, 0));
      send_frame(frame_of(sender_mac[1], 100, 60, 2, 0, 0));
      send_frame(frame_of(sender_mac[1], 100, 60, 255, 1, 0));
      // fragment with no start
      send_frame(frame_of(sender_mac[3], 100, 60, 1, 3, 1));
      for (int i = 0; i < 3; i++) send_frame(frame_of(sender_mac[3], 200, 250, 2, 3, i));
      send_frame(frame_of(sender_mac[1], 200, 250, 1, 2, 0));
      send_frame(frame_of(sender_mac[1], 200, 250, 1, 2, 0));
      send_frame(frame_of(sender_mac[1], 200, 20, 16, 2, 1));
      send_frame(frame_of(sender_mac[3], 200, 50, 1, 4, 0));
      send_frame(frame_of(sender_mac[3], 200, 50, 1, 4, 2));
      // fill every slot, then one more start finds the table full
      for (int i = 0; i < 8; i++) send_frame(frame_of(sender_mac[i], 120, 80, 7, 5, 0));
      send_frame(frame_of(sender_mac[8], 120, 80, 7, 5, 0));

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: mask = 16'hFFFF;
            2: mask = 16'h0000;
            default: mask = CSR_W'($urandom);
         endcase
         write_enable_mask(mask);
         if (p == 1) hold_off_go = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            repeat (burst) begin
               if (sent < ITEMS_PER_PHASE) begin
                  next_random_frame(f);
                  send_frame(f);
                  sent++;
               end
            end
            pause($urandom_range(1, 8));
         end
      end

      req_tvalid <= 1'b0;
      while (decisions_due != 0) @(negedge clock);
      repeat (MAX_SOURCES_DEF + 8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS fragment_reassembly_tracker");
      end else begin
         $display("FAIL fragment_reassembly_tracker");
      end
      $finish;
   end

   initial begin : rsp_side
      rx_pattern_type pattern;
      int             span;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_go) begin
            // long stall so the tracker backs up onto its request side
            hold_off_go = 1'b0;
            repeat (HOLD_OFF_CYCLES) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end
         pattern = rx_pattern_type'($urandom_range(0, 3));
         span    = $urandom_range(20, 150);
         repeat (span) begin
            @(negedge clock);
            case (pattern)
               RX_ALWAYS: rsp_tready <= 1'b1;
               RX_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("FAIL fragment_reassembly_tracker");
      $finish;
   end

endmodule
